[rtl/tpu_pkg.sv]
// Package for the trail particle update unit: field structs, codes, constants.
// No dependencies.
package tpu_pkg;

	localparam int unsigned RecordsDef = 64;
	localparam int unsigned PointsDef  = 9;
	localparam int unsigned QW         = 24;
	localparam logic signed [QW-1:0] QMax = 24'sh7FFFFF;
	localparam logic signed [QW-1:0] QMin = -24'sh800000;
	localparam logic signed [QW-1:0] OffsetQ = 24'sd768;
	localparam logic [7:0] AlphaOpaque = 8'hFF;

	typedef enum logic [1:0] {
		FUNC_POINT  = 2'd0,
		FUNC_MOTION = 2'd1,
		FUNC_COLOUR = 2'd2,
		FUNC_ADVANCE = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		CFG_GRAVITY = 2'd0,
		CFG_WIND_X  = 2'd1,
		CFG_WIND_Z  = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic [1:0]         func;
		logic [5:0]         record_index;
		logic [3:0]         point_index;
		logic signed [23:0] value_a;
		logic signed [23:0] value_b;
		logic signed [23:0] value_c;
		logic signed [23:0] floor_height;
		logic [23:0]        colour;
		logic               make_active;
		logic [3:0]         step_count;
	} item_t;

	typedef struct packed {
		logic signed [15:0] vertex_x;
		logic signed [15:0] vertex_y;
		logic signed [15:0] vertex_z;
		logic [7:0]         red;
		logic [7:0]         green;
		logic [7:0]         blue;
		logic [7:0]         alpha;
		logic               last_vertex;
	} result_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_WRITE, ST_CHECK, ST_HEAD_RD, ST_HEAD_WR, ST_CHAIN_RD, ST_CHAIN_WR,
		ST_STEP_END, ST_DRAW_RD, ST_DRAW_A, ST_DRAW_B
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;
		logic do_write;
		logic head_rd;
		logic head_wr;
		logic chain_rd;
		logic chain_wr;
		logic step_end;
		logic draw_rd;
		logic emit_a;
		logic emit_b;
		logic clr_point;
		logic inc_point;
		logic dec_step;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic is_write;
		logic rec_ok;
		logic active;
		logic last_point;
		logic steps_zero;
	} sts_t;

	function automatic logic signed [QW-1:0] sat_add(input logic signed [QW-1:0] a,
			input logic signed [QW-1:0] b);
		logic signed [QW:0] s;
		s = {a[QW-1], a} + {b[QW-1], b};
		if (s[QW] != s[QW-1]) return s[QW] ? QMin : QMax;
		return s[QW-1:0];
	endfunction

	function automatic logic signed [QW-1:0] sat_sub(input logic signed [QW-1:0] a,
			input logic signed [QW-1:0] b);
		logic signed [QW:0] s;
		s = {a[QW-1], a} - {b[QW-1], b};
		if (s[QW] != s[QW-1]) return s[QW] ? QMin : QMax;
		return s[QW-1:0];
	endfunction

	// point moves a quarter toward its predecessor, floor rounding
	function automatic logic signed [QW-1:0] follow(input logic signed [QW-1:0] pre,
			input logic signed [QW-1:0] cur);
		logic signed [QW:0] d;
		logic signed [QW:0] q;
		logic signed [QW+1:0] s;
		d = {pre[QW-1], pre} - {cur[QW-1], cur};
		q = d >>> 2;
		s = {{2{cur[QW-1]}}, cur} + {q[QW], q};
		if (s > $signed({2'b00, QMax})) return QMax;
		if (s < $signed({2'b11, QMin})) return QMin;
		return s[QW-1:0];
	endfunction

	function automatic logic signed [15:0] to_vertex(input logic signed [QW:0] q);
		logic signed [QW:0] i;
		i = q >>> 8;
		if (q[QW] && (q[7:0] != 8'd0)) i = (q >>> 8) + 25'sd1;
		if (i > 25'sd32767) return 16'sh7FFF;
		if (i < -25'sd32768) return -16'sh8000;
		return i[15:0];
	endfunction

endpackage

[rtl/tpu_ctrl.sv]
// Controller state machine for the trail particle update unit.
// Depends on tpu_pkg.
module tpu_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  tpu_pkg::sts_t  sts,
	output tpu_pkg::cmd_t  cmd
);
	import tpu_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		busy = (state_q != ST_IDLE);
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (sts.is_write) state_d = ST_WRITE;
				else if (!sts.rec_ok || !sts.active) state_d = ST_IDLE;
				else if (sts.steps_zero) begin
					cmd.clr_point = 1'b1;
					state_d = ST_DRAW_RD;
				end else state_d = ST_HEAD_RD;
			end
			ST_WRITE: begin
				cmd.do_write = 1'b1;
				state_d = ST_IDLE;
			end
			ST_HEAD_RD: begin
				cmd.head_rd = 1'b1;
				cmd.clr_point = 1'b1;
				state_d = ST_HEAD_WR;
			end
			ST_HEAD_WR: begin
				cmd.head_wr = 1'b1;
				cmd.inc_point = 1'b1;
				state_d = ST_CHAIN_RD;
			end
			ST_CHAIN_RD: begin
				cmd.chain_rd = 1'b1;
				state_d = ST_CHAIN_WR;
			end
			ST_CHAIN_WR: begin
				cmd.chain_wr = 1'b1;
				cmd.inc_point = 1'b1;
				state_d = sts.last_point ? ST_STEP_END : ST_CHAIN_RD;
			end
			ST_STEP_END: begin
				cmd.step_end = 1'b1;
				cmd.dec_step = 1'b1;
				cmd.clr_point = 1'b1;
				if (!sts.steps_zero) state_d = ST_HEAD_RD;
				else state_d = ST_DRAW_RD;
			end
			ST_DRAW_RD: begin
				if (!sts.active) state_d = ST_IDLE;
				else begin
					cmd.draw_rd = 1'b1;
					state_d = ST_DRAW_A;
				end
			end
			ST_DRAW_A: begin
				cmd.emit_a = 1'b1;
				state_d = ST_DRAW_B;
			end
			ST_DRAW_B: begin
				cmd.emit_b = 1'b1;
				cmd.inc_point = 1'b1;
				state_d = sts.last_point ? ST_IDLE : ST_DRAW_RD;
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule

[rtl/tpu_datapath.sv]
// Datapath of the trail particle update unit: stores, step arithmetic, vertex output.
// Depends on tpu_pkg.
module tpu_datapath #(
	parameter int unsigned RECORDS = tpu_pkg::RecordsDef,
	parameter int unsigned POINTS  = tpu_pkg::PointsDef
) (
	input  logic             clk,
	input  logic             arst_n,
	input  tpu_pkg::item_t   item,
	input  tpu_pkg::cmd_t    cmd,
	output tpu_pkg::sts_t    sts,
	input  logic signed [23:0] gravity,
	input  logic signed [23:0] wind_x,
	input  logic signed [23:0] wind_z,
	output logic             result_valid,
	output tpu_pkg::result_t result
);
	import tpu_pkg::*;

	localparam int unsigned RW = (RECORDS > 1) ? $clog2(RECORDS) : 1;
	localparam int unsigned PW = $clog2(POINTS);
	localparam int unsigned DEPTH = RECORDS * POINTS;
	localparam int unsigned AW = $clog2(DEPTH);

	logic [QW-1:0] px_mem [DEPTH];
	logic [QW-1:0] py_mem [DEPTH];
	logic [QW-1:0] pz_mem [DEPTH];
	logic [QW-1:0] vx_mem [RECORDS];
	logic [QW-1:0] vy_mem [RECORDS];
	logic [QW-1:0] vz_mem [RECORDS];
	logic [QW-1:0] fl_mem [RECORDS];
	logic [QW-1:0] col_mem [RECORDS];
	logic [RECORDS-1:0] active_q;

	item_t item_q;
	logic [RW-1:0] rec;
	logic [PW-1:0] pt_q;
	logic [3:0] steps_q;
	logic [AW-1:0] base, addr;
	logic signed [QW-1:0] prex_q, prey_q, prez_q;
	logic signed [QW-1:0] rx_q, ry_q, rz_q;
	logic signed [QW-1:0] vx_q, vy_q, vz_q, fl_q;
	logic signed [QW-1:0] heady_q;
	logic [QW-1:0] col_q;
	logic signed [QW-1:0] nx, ny, nz;

	assign rec  = RW'(item_q.record_index);
	assign base = AW'(rec) * AW'(POINTS);
	assign addr = cmd.do_write ? AW'(base + AW'(item_q.point_index)) : AW'(base + AW'(pt_q));

	assign sts.is_write   = (item_q.func != FUNC_ADVANCE);
	assign sts.rec_ok     = (32'(item_q.record_index) < RECORDS);
	assign sts.active     = active_q[rec];
	assign sts.last_point = (32'(pt_q) == POINTS - 1);
	assign sts.steps_zero = (cmd.dec_step ? steps_q == 4'd1 : steps_q == 4'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= '0;
			steps_q  <= '0;
			pt_q     <= '0;
		end else begin
			if (cmd.load) steps_q <= item.step_count;
			else if (cmd.dec_step) steps_q <= steps_q - 4'd1;
			if (cmd.clr_point) pt_q <= '0;
			else if (cmd.inc_point) pt_q <= sts.last_point ? '0 : pt_q + 1'b1;
			if (cmd.do_write && sts.rec_ok && item_q.func == FUNC_COLOUR)
				active_q[rec] <= item_q.make_active;
			if (cmd.step_end && sts.rec_ok && (heady_q < fl_q))
				active_q[rec] <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) item_q <= item;
		if (cmd.head_rd) begin
			vx_q <= vx_mem[rec];
			vy_q <= vy_mem[rec];
			vz_q <= vz_mem[rec];
			fl_q <= fl_mem[rec];
		end
		if (cmd.head_rd || cmd.chain_rd || cmd.draw_rd) begin
			rx_q <= px_mem[addr];
			ry_q <= py_mem[addr];
			rz_q <= pz_mem[addr];
		end
		if (cmd.draw_rd) col_q <= col_mem[rec];
		if (cmd.do_write && sts.rec_ok) begin
			unique case (func_t'(item_q.func))
				FUNC_POINT: begin
					if (32'(item_q.point_index) < POINTS) begin
						px_mem[addr] <= item_q.value_a;
						py_mem[addr] <= item_q.value_b;
						pz_mem[addr] <= item_q.value_c;
					end
				end
				FUNC_MOTION: begin
					vx_mem[rec] <= item_q.value_a;
					vy_mem[rec] <= item_q.value_b;
					vz_mem[rec] <= item_q.value_c;
					fl_mem[rec] <= item_q.floor_height;
				end
				FUNC_COLOUR: col_mem[rec] <= item_q.colour;
				default: ;
			endcase
		end
		if (cmd.head_wr || cmd.chain_wr) begin
			px_mem[addr] <= sat_add(nx, wind_x);
			py_mem[addr] <= ny;
			pz_mem[addr] <= sat_add(nz, wind_z);
			prex_q <= nx;
			prey_q <= ny;
			prez_q <= nz;
		end
		// head y is final after its write; the floor test uses this copy
		if (cmd.head_wr) heady_q <= ny;
		if (cmd.step_end) vy_mem[rec] <= sat_sub(vy_q, gravity);
	end

	// predecessor is kept before wind so the chain sees pre-wind values
	always_comb begin
		if (cmd.head_wr) begin
			nx = sat_add(rx_q, vx_q);
			ny = sat_add(ry_q, vy_q);
			nz = sat_add(rz_q, vz_q);
		end else begin
			nx = follow(prex_q, rx_q);
			ny = follow(prey_q, ry_q);
			nz = follow(prez_q, rz_q);
		end
	end

	logic signed [QW:0] off;
	assign off = cmd.emit_a ? -{OffsetQ[QW-1], OffsetQ} : {OffsetQ[QW-1], OffsetQ};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) result_valid <= 1'b0;
		else result_valid <= cmd.emit_a || cmd.emit_b;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_a || cmd.emit_b) begin
			result.vertex_x    <= to_vertex({rx_q[QW-1], rx_q} + off);
			result.vertex_y    <= to_vertex({ry_q[QW-1], ry_q});
			result.vertex_z    <= to_vertex({rz_q[QW-1], rz_q} + off);
			result.red         <= col_q[23:16];
			result.green       <= col_q[15:8];
			result.blue        <= col_q[7:0];
			result.alpha       <= AlphaOpaque;
			result.last_vertex <= cmd.emit_b && sts.last_point;
		end
	end
endmodule

[rtl/trail_particle_update_unit.sv]
// Top level of the trail particle update unit: config registers, controller, datapath.
// Depends on tpu_pkg, tpu_ctrl, tpu_datapath.
//
// A write passes through the check and write states. An advance of N steps on an
// active record walks the chain N times, reading then writing each point in turn,
// then emits 2*POINTS vertices if still active. Results appear with result_valid
// for one cycle each and cannot be stalled. Config writes are always ready.
module trail_particle_update_unit #(
	parameter int unsigned RECORDS = tpu_pkg::RecordsDef,
	parameter int unsigned POINTS  = tpu_pkg::PointsDef
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  tpu_pkg::item_t     item,
	output logic               result_valid,
	output tpu_pkg::result_t   result,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [23:0]        cfg_data
);
	import tpu_pkg::*;

	logic signed [23:0] gravity_q, wind_x_q, wind_z_q;
	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gravity_q <= '0;
			wind_x_q  <= '0;
			wind_z_q  <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_GRAVITY: gravity_q <= cfg_data;
				CFG_WIND_X:  wind_x_q  <= cfg_data;
				CFG_WIND_Z:  wind_z_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	tpu_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .sts(sts), .cmd(cmd)
	);

	tpu_datapath #(.RECORDS(RECORDS), .POINTS(POINTS)) u_dp (
		.clk(clk), .arst_n(arst_n), .item(item), .cmd(cmd), .sts(sts),
		.gravity(gravity_q), .wind_x(wind_x_q), .wind_z(wind_z_q),
		.result_valid(result_valid), .result(result)
	);

	a_no_out_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(busy)) else $error("result while idle");
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.last_vertex |-> !busy) else $error("last vertex not final");
	a_alpha: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.alpha == AlphaOpaque) else $error("alpha wrong");
endmodule

[verif/trail_particle_update_unit_test.sv]
// Testbench for trail_particle_update_unit: directed and random items checked
// against an in-bench predictor of the trail physics. Depends on tpu_pkg and the RTL.
`timescale 1ns / 100ps

module trail_particle_update_unit_test;
	import tpu_pkg::*;

	localparam int NREC = 64;
	localparam int NPT  = 9;
	localparam int ItemW = $bits(item_t);
	localparam logic signed [24:0] OFS = 25'sd768;

	class vertex_scoreboard;
		logic signed [23:0] px [NREC*NPT];
		logic signed [23:0] py [NREC*NPT];
		logic signed [23:0] pz [NREC*NPT];
		logic signed [23:0] vx [NREC];
		logic signed [23:0] vy [NREC];
		logic signed [23:0] vz [NREC];
		logic signed [23:0] flr [NREC];
		logic [23:0] col [NREC];
		bit act [NREC];
		logic signed [23:0] grav, wx, wz;
		result_t pending [$];
		int errors;

		function new();
			errors = 0; grav = 0; wx = 0; wz = 0;
			foreach (act[i]) act[i] = 0;
		endfunction

		function logic signed [23:0] sat(longint v);
			if (v > 8388607) return 24'sh7FFFFF;
			if (v < -8388608) return -24'sh800000;
			return v[23:0];
		endfunction

		function logic [15:0] vert(longint q);
			longint i;
			i = (q >= 0) ? q / 256 : -((-q) / 256);
			if (i > 32767) i = 32767;
			if (i < -32768) i = -32768;
			return i[15:0];
		endfunction

		function void set_reg(cfg_idx_t idx, logic [23:0] d);
			case (idx)
				CFG_GRAVITY: grav = d;
				CFG_WIND_X: wx = d;
				default: wz = d;
			endcase
		endfunction

		function void advance_once(int r);
			int b, c;
			longint d;
			b = r * NPT;
			px[b] = sat(longint'(px[b]) + vx[r]);
			py[b] = sat(longint'(py[b]) + vy[r]);
			pz[b] = sat(longint'(pz[b]) + vz[r]);
			for (int p = 1; p < NPT; p++) begin
				c = b + p;
				d = longint'(px[c-1]) - px[c]; px[c] = sat(px[c] + (d >>> 2));
				d = longint'(py[c-1]) - py[c]; py[c] = sat(py[c] + (d >>> 2));
				d = longint'(pz[c-1]) - pz[c]; pz[c] = sat(pz[c] + (d >>> 2));
			end
			for (int p = 0; p < NPT; p++) begin
				px[b+p] = sat(longint'(px[b+p]) + wx);
				pz[b+p] = sat(longint'(pz[b+p]) + wz);
			end
			vy[r] = sat(longint'(vy[r]) - grav);
			if (py[b] < flr[r]) act[r] = 0;
		endfunction

		function void note_item(item_t it);
			int r, b;
			result_t e;
			r = int'(it.record_index); b = r * NPT;
			case (func_t'(it.func))
				FUNC_POINT: if (it.point_index < NPT) begin
					px[b+it.point_index] = it.value_a;
					py[b+it.point_index] = it.value_b;
					pz[b+it.point_index] = it.value_c;
				end
				FUNC_MOTION: begin
					vx[r] = it.value_a; vy[r] = it.value_b; vz[r] = it.value_c;
					flr[r] = it.floor_height;
				end
				FUNC_COLOUR: begin
					col[r] = it.colour; act[r] = it.make_active;
				end
				default: if (act[r]) begin
					for (int s = 0; s < it.step_count; s++) advance_once(r);
					if (act[r])
						for (int p = 0; p < NPT; p++)
							for (int sd = 0; sd < 2; sd++) begin
								e.vertex_x = vert(longint'(px[b+p]) + (sd ? OFS : -OFS));
								e.vertex_y = vert(longint'(py[b+p]));
								e.vertex_z = vert(longint'(pz[b+p]) + (sd ? OFS : -OFS));
								e.red = col[r][23:16]; e.green = col[r][15:8];
								e.blue = col[r][7:0]; e.alpha = 8'hFF;
								e.last_vertex = (p == NPT-1 && sd == 1);
								pending.push_back(e);
							end
				end
			endcase
		endfunction

		function void check_vertex(result_t got);
			result_t e;
			if (pending.size() == 0) begin
				$display("%0t: unexpected vertex %h", $time, got);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (got !== e) begin
				$display("%0t: vertex mismatch expected %h actual %h", $time, e, got);
				errors++;
			end
		endfunction
	endclass

	logic clk, arst_n, start, busy, result_valid, cfg_valid, cfg_ready;
	item_t item;
	result_t result;
	logic [1:0] cfg_index;
	logic [23:0] cfg_data;
	vertex_scoreboard sb;
	bit [NREC-1:0] ready_rec;

	trail_particle_update_unit i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.result_valid(result_valid), .result(result), .cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && result_valid) sb.check_vertex(result);
	end

	task automatic idle_gap();
		int n;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
		repeat (n) @(negedge clk);
	endtask

	task automatic send(item_t it);
		item <= it;
		start <= 1;
		@(posedge clk);
		while (busy) @(posedge clk);
		sb.note_item(it);
		@(negedge clk);
		start <= 0;
		item <= item_t'(ItemW'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom}));
		idle_gap();
	endtask

	task automatic drain();
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (16 * 19 + 40) @(negedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [23:0] d);
		cfg_valid <= 1; cfg_index <= idx; cfg_data <= d;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.set_reg(idx, d);
		@(negedge clk);
		cfg_valid <= 0;
		idle_gap();
	endtask

	function automatic logic [23:0] rq();
		case ($urandom_range(0, 5))
			0: return 24'h7FFFFF;
			1: return 24'h800000;
			2: return 24'(int'($urandom_range(0, 4000)) - 2000);
			default: return 24'($urandom);
		endcase
	endfunction

	function automatic item_t mk(func_t f, int r, int p, int steps);
		item_t it;
		it = item_t'(ItemW'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom}));
		it.func = f; it.record_index = 6'(r); it.point_index = 4'(p);
		it.step_count = 4'(steps);
		it.value_a = rq(); it.value_b = rq(); it.value_c = rq(); it.floor_height = rq();
		return it;
	endfunction

	// loads every point and the motion so an advance never reads unwritten entries
	task automatic load_record(int r, bit wild);
		item_t it;
		for (int p = 0; p < NPT; p++) begin
			it = mk(FUNC_POINT, r, p, 0);
			if (!wild) begin
				it.value_a = 24'(int'($urandom_range(0, 20000)) - 10000);
				it.value_b = 24'(int'($urandom_range(0, 20000)) - 10000);
				it.value_c = 24'(int'($urandom_range(0, 20000)) - 10000);
			end
			send(it);
		end
		it = mk(FUNC_MOTION, r, 0, 0);
		if (!wild) begin
			it.value_a = 24'(int'($urandom_range(0, 400)) - 200);
			it.value_b = 24'(int'($urandom_range(0, 400)) - 200);
			it.value_c = 24'(int'($urandom_range(0, 400)) - 200);
			it.floor_height = -24'sd3000000;
		end
		send(it);
		it = mk(FUNC_COLOUR, r, 0, 0);
		it.make_active = 1;
		send(it);
		ready_rec[r] = 1;
	endtask

	task automatic random_phase(int n);
		item_t it;
		int r;
		for (int k = 0; k < n; k++) begin
			r = $urandom_range(0, 3);
			if (!ready_rec[r]) load_record(r, $urandom_range(0, 3) == 0);
			case ($urandom_range(0, 9))
				0: send(mk(FUNC_POINT, r, $urandom_range(0, 15), 0));
				1: send(mk(FUNC_MOTION, r, 0, 0));
				2: begin
					it = mk(FUNC_COLOUR, r, 0, 0);
					it.make_active = $urandom_range(0, 4) != 0;
					send(it);
				end
				default: send(mk(FUNC_ADVANCE, r, 0, $urandom_range(0, 15)));
			endcase
		end
	endtask

	initial begin
		item_t it;
		sb = new();
		ready_rec = 0;
		start = 0; cfg_valid = 0; cfg_index = CFG_GRAVITY; cfg_data = 0;
		item = '0;
		arst_n = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// advance on an inactive record, index out of range on a point write
		send(mk(FUNC_ADVANCE, 63, 0, 5));
		send(mk(FUNC_POINT, 63, 9, 0));
		send(mk(FUNC_POINT, 63, 15, 0));
		load_record(0, 1'b0);
		send(mk(FUNC_ADVANCE, 0, 0, 0));
		send(mk(FUNC_ADVANCE, 0, 0, 15));
		load_record(1, 1'b1);
		send(mk(FUNC_ADVANCE, 1, 0, 1));
		it = mk(FUNC_MOTION, 0, 0, 0);
		it.value_b = -24'sd100000; it.floor_height = 24'sh7FFFFF;
		send(it);
		send(mk(FUNC_ADVANCE, 0, 0, 3));
		ready_rec[0] = 0;
		drain();

		write_reg(CFG_GRAVITY, 24'd40);
		write_reg(CFG_WIND_X, 24'hFFFFF0);
		write_reg(CFG_WIND_Z, 24'd25);
		random_phase(25);
		drain();
		write_reg(CFG_GRAVITY, 24'h800000);
		write_reg(CFG_WIND_X, 24'h7FFFFF);
		write_reg(CFG_WIND_Z, 24'h800000);
		random_phase(20);
		drain();
		write_reg(CFG_GRAVITY, 24'h7FFFFF);
		write_reg(CFG_WIND_X, 24'h800000);
		write_reg(CFG_WIND_Z, 24'h7FFFFF);
		random_phase(20);
		drain();
		write_reg(CFG_GRAVITY, 24'($urandom));
		write_reg(CFG_WIND_X, 24'($urandom));
		write_reg(CFG_WIND_Z, 24'($urandom));
		random_phase(22);
		drain();

		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end
endmodule

[filelist.f]
rtl/tpu_pkg.sv
rtl/tpu_ctrl.sv
rtl/tpu_datapath.sv
rtl/trail_particle_update_unit.sv
verif/trail_particle_update_unit_test.sv
